// File: hw/rtl/dcr_pkg.sv
// dcr_pkg: shared constants and types of the disc collision response core
// no dependencies
package dcr_pkg;

   localparam int DCR_POSITION_WIDTH = 18;
   localparam int DCR_VELOCITY_WIDTH = 16;
   localparam int DCR_RADIUS_WIDTH   = 12;

   // per-pair decisions that travel alongside the divider
   typedef struct packed {
      logic touch;
      logic same;
      logic neg_x;
      logic neg_y;
   } dcr_flags_type;

endpackage

// File: hw/rtl/dcr_if.sv
// dcr_req_if and dcr_rsp_if: valid/ready channels of the collision core
// depends on dcr_pkg
interface dcr_req_if import dcr_pkg::*; #(
   parameter int POSITION_WIDTH = DCR_POSITION_WIDTH,
   parameter int VELOCITY_WIDTH = DCR_VELOCITY_WIDTH
) ();
   logic                             valid;
   logic                             ready;
   logic signed [POSITION_WIDTH-1:0] first_pos_x;
   logic signed [POSITION_WIDTH-1:0] first_pos_y;
   logic signed [POSITION_WIDTH-1:0] second_pos_x;
   logic signed [POSITION_WIDTH-1:0] second_pos_y;
   logic signed [VELOCITY_WIDTH-1:0] first_vel_x;
   logic signed [VELOCITY_WIDTH-1:0] first_vel_y;
   logic signed [VELOCITY_WIDTH-1:0] second_vel_x;
   logic signed [VELOCITY_WIDTH-1:0] second_vel_y;
   logic [DCR_RADIUS_WIDTH-1:0]      first_radius;
   logic [DCR_RADIUS_WIDTH-1:0]      second_radius;

   modport source (output valid, first_pos_x, first_pos_y, second_pos_x, second_pos_y,
                   first_vel_x, first_vel_y, second_vel_x, second_vel_y,
                   first_radius, second_radius, input ready);
   modport sink (input valid, first_pos_x, first_pos_y, second_pos_x, second_pos_y,
                 first_vel_x, first_vel_y, second_vel_x, second_vel_y,
                 first_radius, second_radius, output ready);
endinterface

interface dcr_rsp_if import dcr_pkg::*; #(
   parameter int VELOCITY_WIDTH = DCR_VELOCITY_WIDTH
) ();
   logic                             valid;
   logic                             ready;
   logic signed [VELOCITY_WIDTH-1:0] new_first_vel_x;
   logic signed [VELOCITY_WIDTH-1:0] new_first_vel_y;
   logic signed [VELOCITY_WIDTH-1:0] new_second_vel_x;
   logic signed [VELOCITY_WIDTH-1:0] new_second_vel_y;
   logic                             touching;
   logic                             coincident;
   logic                             clipped;

   modport source (output valid, new_first_vel_x, new_first_vel_y, new_second_vel_x,
                   new_second_vel_y, touching, coincident, clipped, input ready);
   modport sink (input valid, new_first_vel_x, new_first_vel_y, new_second_vel_x,
                 new_second_vel_y, touching, coincident, clipped, output ready);
endinterface

// File: hw/rtl/dcr_geom.sv
// dcr_geom: five-stage front end, differences, squares, dot product, dividends
// depends on dcr_pkg
module dcr_geom import dcr_pkg::*; #(
   parameter int POSITION_WIDTH = DCR_POSITION_WIDTH,
   parameter int VELOCITY_WIDTH = DCR_VELOCITY_WIDTH,
   localparam int P = POSITION_WIDTH,
   localparam int V = VELOCITY_WIDTH,
   localparam int DEN_W = 2 * P + 2,
   localparam int DIV_W = 2 * P + V + 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic signed [P-1:0]   p1x, p1y, p2x, p2y,
   input  logic signed [V-1:0]   v1x, v1y, v2x, v2y,
   input  logic [DCR_RADIUS_WIDTH-1:0] r1, r2,
   output logic                  out_valid,
   output logic [DIV_W-1:0]      dividend_x,
   output logic [DIV_W-1:0]      dividend_y,
   output logic [DEN_W-1:0]      divisor,
   output logic signed [V-1:0]   out_v1x, out_v1y, out_v2x, out_v2y,
   output dcr_flags_type         flags
);
   localparam int NSTG  = 5;
   localparam int RS_W  = DCR_RADIUS_WIDTH + 1;
   localparam int RCH_W = 2 * RS_W;
   localparam int PR_W  = V + P + 2;
   localparam int DOT_W = V + P + 3;
   localparam int NUM_W = V + 2 * P + 3;

   typedef struct packed {
      logic signed [V-1:0] v1x;
      logic signed [V-1:0] v1y;
      logic signed [V-1:0] v2x;
      logic signed [V-1:0] v2y;
   } vel_type;

   logic    valid_ff [NSTG];
   vel_type vel_ff [NSTG];

   // stage 1: differences and radius sum
   logic signed [P:0]   dx_in, dy_in, dx1_ff, dy1_ff;
   logic signed [V:0]   dvx_in, dvy_in, dvx_ff, dvy_ff;
   logic [RS_W-1:0]     rsum_in, rsum_ff;
   assign dx_in   = (P+1)'(p1x) - (P+1)'(p2x);
   assign dy_in   = (P+1)'(p1y) - (P+1)'(p2y);
   assign dvx_in  = (V+1)'(v1x) - (V+1)'(v2x);
   assign dvy_in  = (V+1)'(v1y) - (V+1)'(v2y);
   assign rsum_in = RS_W'(r1) + RS_W'(r2);
   always_ff @(posedge clock) begin
      if (en) begin
         dx1_ff  <= dx_in;
         dy1_ff  <= dy_in;
         dvx_ff  <= dvx_in;
         dvy_ff  <= dvy_in;
         rsum_ff <= rsum_in;
      end
   end

   // stage 2: squares and velocity projections
   logic signed [DEN_W-1:0] sqx_in, sqy_in, sqx_ff, sqy_ff;
   logic [RCH_W-1:0]        reach_in, reach_ff;
   logic signed [PR_W-1:0]  prx_in, pry_in, prx_ff, pry_ff;
   logic signed [P:0]       dx2_ff, dy2_ff;
   assign sqx_in   = DEN_W'(dx1_ff) * DEN_W'(dx1_ff);
   assign sqy_in   = DEN_W'(dy1_ff) * DEN_W'(dy1_ff);
   assign reach_in = RCH_W'(rsum_ff) * RCH_W'(rsum_ff);
   assign prx_in   = PR_W'(dvx_ff) * PR_W'(dx1_ff);
   assign pry_in   = PR_W'(dvy_ff) * PR_W'(dy1_ff);
   always_ff @(posedge clock) begin
      if (en) begin
         sqx_ff   <= sqx_in;
         sqy_ff   <= sqy_in;
         reach_ff <= reach_in;
         prx_ff   <= prx_in;
         pry_ff   <= pry_in;
         dx2_ff   <= dx1_ff;
         dy2_ff   <= dy1_ff;
      end
   end

   // stage 3: squared distance, contact test, dot product
   logic [DEN_W-1:0]       dist_in, dist3_ff;
   logic                   touch_in, touch_ff, same_in, same_ff;
   logic signed [DOT_W-1:0] dot_in, dot_ff;
   logic signed [P:0]      dx3_ff, dy3_ff;
   assign dist_in  = $unsigned(sqx_ff) + $unsigned(sqy_ff);
   assign touch_in = DEN_W'(reach_ff) >= dist_in;
   assign same_in  = dist_in == '0;
   assign dot_in   = DOT_W'(prx_ff) + DOT_W'(pry_ff);
   always_ff @(posedge clock) begin
      if (en) begin
         dist3_ff <= dist_in;
         touch_ff <= touch_in;
         same_ff  <= same_in;
         dot_ff   <= dot_in;
         dx3_ff   <= dx2_ff;
         dy3_ff   <= dy2_ff;
      end
   end

   // stage 4: magnitudes and numerators
   logic [PR_W-1:0]     dmag;
   logic [P:0]          adx, ady;
   logic [NUM_W-1:0]    numx_in, numy_in, numx_ff, numy_ff;
   logic [DEN_W-1:0]    dist4_ff;
   dcr_flags_type       flags_in, flags4_ff, flags5_ff;
   assign dmag    = dot_ff[DOT_W-1] ? PR_W'(-dot_ff) : PR_W'(dot_ff);
   assign adx     = dx3_ff[P] ? $unsigned(-dx3_ff) : $unsigned(dx3_ff);
   assign ady     = dy3_ff[P] ? $unsigned(-dy3_ff) : $unsigned(dy3_ff);
   assign numx_in = NUM_W'(dmag) * NUM_W'(adx);
   assign numy_in = NUM_W'(dmag) * NUM_W'(ady);
   always_comb begin
      flags_in.touch = touch_ff;
      flags_in.same  = same_ff;
      flags_in.neg_x = dot_ff[DOT_W-1] ^ dx3_ff[P];
      flags_in.neg_y = dot_ff[DOT_W-1] ^ dy3_ff[P];
   end
   always_ff @(posedge clock) begin
      if (en) begin
         numx_ff   <= numx_in;
         numy_ff   <= numy_in;
         dist4_ff  <= dist3_ff;
         flags4_ff <= flags_in;
      end
   end

   // stage 5: add half the divisor for round to nearest
   logic [DIV_W-1:0] divx_in, divy_in, divx_ff, divy_ff;
   logic [DEN_W-1:0] dist5_ff;
   assign divx_in = DIV_W'(numx_ff) + DIV_W'(dist4_ff >> 1);
   assign divy_in = DIV_W'(numy_ff) + DIV_W'(dist4_ff >> 1);
   always_ff @(posedge clock) begin
      if (en) begin
         divx_ff   <= divx_in;
         divy_ff   <= divy_in;
         dist5_ff  <= dist4_ff;
         flags5_ff <= flags4_ff;
      end
   end

   // valid bits and velocities ride along
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NSTG; k++) valid_ff[k] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < NSTG; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         vel_ff[0] <= '{v1x: v1x, v1y: v1y, v2x: v2x, v2y: v2y};
         for (int k = 1; k < NSTG; k++) vel_ff[k] <= vel_ff[k-1];
      end
   end

   assign out_valid  = valid_ff[NSTG-1];
   assign dividend_x = divx_ff;
   assign dividend_y = divy_ff;
   assign divisor    = dist5_ff;
   assign flags      = flags5_ff;
   assign out_v1x    = vel_ff[NSTG-1].v1x;
   assign out_v1y    = vel_ff[NSTG-1].v1y;
   assign out_v2x    = vel_ff[NSTG-1].v2x;
   assign out_v2y    = vel_ff[NSTG-1].v2y;
endmodule

// File: hw/rtl/dcr_div.sv
// dcr_div: pipelined restoring divider, one quotient bit per stage
// depends on dcr_pkg
module dcr_div import dcr_pkg::*; #(
   parameter int DEN_W = 2 * DCR_POSITION_WIDTH + 2,
   parameter int Q_W   = DCR_VELOCITY_WIDTH + 2,
   localparam int W    = DEN_W + Q_W
) (
   input  logic             clock,
   input  logic             en,
   input  logic [W-1:0]     dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic [Q_W-1:0]   quotient
);
   // caller guarantees the quotient stays below 2**Q_W
   logic [W-1:0]     rem_ff [Q_W];
   logic [DEN_W-1:0] den_ff [Q_W];
   logic [Q_W-1:0]   q_ff   [Q_W];

   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      localparam int S = Q_W - 1 - k;
      logic [W-1:0]     src_rem;
      logic [DEN_W-1:0] src_den;
      logic [Q_W-1:0]   src_q;
      logic [W:0]       trial;
      if (k == 0) begin : g_first
         assign src_rem = dividend;
         assign src_den = divisor;
         assign src_q   = '0;
      end else begin : g_next
         assign src_rem = rem_ff[k-1];
         assign src_den = den_ff[k-1];
         assign src_q   = q_ff[k-1];
      end
      // trial subtract of the shifted divisor
      assign trial = {1'b0, src_rem} - ((W+1)'(src_den) << S);
      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[k] <= trial[W] ? src_q : (src_q | (Q_W'(1) << S));
         end
      end
      if (k < Q_W - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= trial[W] ? src_rem : trial[W-1:0];
               den_ff[k] <= src_den;
            end
         end
      end
   end

   assign quotient = q_ff[Q_W-1];
endmodule

// File: hw/rtl/disc_collision_response_core.sv
// disc_collision_response_core: equal-mass elastic response of two discs
// depends on dcr_pkg, dcr_if, dcr_geom, dcr_div
//
//   channel  dir  beat contents
//   req_bus  in   two disc centres, velocities and radii
//   rsp_bus  out  new velocities, touching, coincident, clipped
//
// one pair enters per cycle while rsp_bus is not stalled; the path runs through dcr_geom,
// the two pipelined dividers, one quotient bit per stage, and the output register
// reset clears the valid bits only
// a stall at rsp_bus holds every stage; req_bus.ready is low only then
module disc_collision_response_core import dcr_pkg::*; #(
   parameter int POSITION_WIDTH = DCR_POSITION_WIDTH,
   parameter int VELOCITY_WIDTH = DCR_VELOCITY_WIDTH
) (
   input  logic   clock,
   input  logic   reset,
   dcr_req_if.sink   req_bus,
   dcr_rsp_if.source rsp_bus
);
   localparam int V     = VELOCITY_WIDTH;
   localparam int DEN_W = 2 * POSITION_WIDTH + 2;
   localparam int Q_W   = V + 2;
   localparam int DIV_W = DEN_W + Q_W;
   localparam int SUM_W = V + 4;

   typedef struct packed {
      dcr_flags_type       flags;
      logic signed [V-1:0] v1x;
      logic signed [V-1:0] v1y;
      logic signed [V-1:0] v2x;
      logic signed [V-1:0] v2y;
   } side_type;

   logic adv;
   logic out_valid_ff;
   assign adv           = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = adv;

   // front end
   logic                g_valid;
   logic [DIV_W-1:0]    g_divx, g_divy;
   logic [DEN_W-1:0]    g_den;
   logic signed [V-1:0] g_v1x, g_v1y, g_v2x, g_v2y;
   dcr_flags_type       g_flags;

   dcr_geom #(.POSITION_WIDTH(POSITION_WIDTH), .VELOCITY_WIDTH(VELOCITY_WIDTH)) u_geom (
      .clock      (clock),
      .reset      (reset),
      .en         (adv),
      .in_valid   (req_bus.valid),
      .p1x        (req_bus.first_pos_x),
      .p1y        (req_bus.first_pos_y),
      .p2x        (req_bus.second_pos_x),
      .p2y        (req_bus.second_pos_y),
      .v1x        (req_bus.first_vel_x),
      .v1y        (req_bus.first_vel_y),
      .v2x        (req_bus.second_vel_x),
      .v2y        (req_bus.second_vel_y),
      .r1         (req_bus.first_radius),
      .r2         (req_bus.second_radius),
      .out_valid  (g_valid),
      .dividend_x (g_divx),
      .dividend_y (g_divy),
      .divisor    (g_den),
      .out_v1x    (g_v1x),
      .out_v1y    (g_v1y),
      .out_v2x    (g_v2x),
      .out_v2y    (g_v2y),
      .flags      (g_flags)
   );

   // dividers, one per component
   logic [Q_W-1:0] qx, qy;
   dcr_div #(.DEN_W(DEN_W), .Q_W(Q_W)) u_div_x (
      .clock (clock), .en (adv), .dividend (g_divx), .divisor (g_den), .quotient (qx)
   );
   dcr_div #(.DEN_W(DEN_W), .Q_W(Q_W)) u_div_y (
      .clock (clock), .en (adv), .dividend (g_divy), .divisor (g_den), .quotient (qy)
   );

   // side line matching the divider depth
   logic     side_valid_ff [Q_W];
   side_type side_ff [Q_W];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < Q_W; k++) side_valid_ff[k] <= 1'b0;
      end else if (adv) begin
         side_valid_ff[0] <= g_valid;
         for (int k = 1; k < Q_W; k++) side_valid_ff[k] <= side_valid_ff[k-1];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0].flags <= g_flags;
         side_ff[0].v1x   <= g_v1x;
         side_ff[0].v1y   <= g_v1y;
         side_ff[0].v2x   <= g_v2x;
         side_ff[0].v2y   <= g_v2y;
         for (int k = 1; k < Q_W; k++) begin
            side_ff[k].flags <= side_ff[k-1].flags;
            side_ff[k].v1x   <= side_ff[k-1].v1x;
            side_ff[k].v1y   <= side_ff[k-1].v1y;
            side_ff[k].v2x   <= side_ff[k-1].v2x;
            side_ff[k].v2y   <= side_ff[k-1].v2y;
         end
      end
   end

   function automatic logic signed [V-1:0] clamp(input logic signed [SUM_W-1:0] x,
                                                 output logic hit);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'({1'b0, {(V-1){1'b1}}});
      lo = -hi - SUM_W'(1);
      hit = 1'b0;
      if (x > hi) begin
         hit = 1'b1;
         return hi[V-1:0];
      end
      if (x < lo) begin
         hit = 1'b1;
         return lo[V-1:0];
      end
      return x[V-1:0];
   endfunction

   // apply the impulse and saturate, or pass the velocities through outside a collision
   side_type                 last;
   logic signed [SUM_W-1:0]  cx, cy;
   logic                     act;
   logic [3:0]               hit;
   logic signed [V-1:0]      n1x_in, n1y_in, n2x_in, n2y_in;
   logic                     clip_in;
   assign last = side_ff[Q_W-1];
   assign act  = last.flags.touch && !last.flags.same;
   assign cx   = last.flags.neg_x ? -SUM_W'(qx) : SUM_W'(qx);
   assign cy   = last.flags.neg_y ? -SUM_W'(qy) : SUM_W'(qy);
   always_comb begin
      n1x_in = clamp(SUM_W'(last.v1x) - cx, hit[0]);
      n1y_in = clamp(SUM_W'(last.v1y) - cy, hit[1]);
      n2x_in = clamp(SUM_W'(last.v2x) + cx, hit[2]);
      n2y_in = clamp(SUM_W'(last.v2y) + cy, hit[3]);
      clip_in = act && (hit != '0);
      if (!act) begin
         n1x_in = last.v1x;
         n1y_in = last.v1y;
         n2x_in = last.v2x;
         n2y_in = last.v2y;
      end
   end

   // output register
   logic signed [V-1:0] o1x_ff, o1y_ff, o2x_ff, o2y_ff;
   logic                touch_ff, same_ff, clip_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= side_valid_ff[Q_W-1];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         o1x_ff   <= n1x_in;
         o1y_ff   <= n1y_in;
         o2x_ff   <= n2x_in;
         o2y_ff   <= n2y_in;
         touch_ff <= last.flags.touch;
         same_ff  <= last.flags.same;
         clip_ff  <= clip_in;
      end
   end

   assign rsp_bus.valid            = out_valid_ff;
   assign rsp_bus.new_first_vel_x  = o1x_ff;
   assign rsp_bus.new_first_vel_y  = o1y_ff;
   assign rsp_bus.new_second_vel_x = o2x_ff;
   assign rsp_bus.new_second_vel_y = o2y_ff;
   assign rsp_bus.touching         = touch_ff;
   assign rsp_bus.coincident       = same_ff;
   assign rsp_bus.clipped          = clip_ff;

   // checks
   a_same_touch: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.coincident |-> rsp_bus.touching)
      else $error("coincident beat without touching");
   a_clip_act: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.clipped |-> rsp_bus.touching && !rsp_bus.coincident)
      else $error("clipped beat outside a collision");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |-> !req_bus.ready)
      else $error("input taken during output stall");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(side_valid_ff[Q_W-1]))
      else $error("pipeline moved during stall");
endmodule
